// ===== sv/ddsfw_pkg.sv =====
// ----------------------------------------------------------------------------
// DDS frequency word programmer package
// Shared command codes, sequencer states, DDS word constants and divider types.
// ----------------------------------------------------------------------------
package ddsfw_pkg;

  // Command kinds on the input channel
  typedef enum logic [1:0] {
    KIND_FREQ = 2'd0,
    KIND_INIT = 2'd1,
    KIND_TUNE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_MIN_FREQ = 2'd1,
    REG_MAX_FREQ = 2'd2,
    REG_MCLK = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV_START,
    ST_DIV,
    ST_EMIT
  } seq_state_t;

  localparam int unsigned FREQ_W = 25;
  localparam int unsigned TW_W = 32;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned HALF_W = 14;
  localparam int unsigned TUNE_SHIFT = 28;
  localparam int unsigned DIV_STEPS = TW_W + TUNE_SHIFT;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] WORD_TAG = 16'h4000;
  localparam logic [WORD_W-1:0] CMD_RESET = 16'h1000;
  localparam logic [WORD_W-1:0] CMD_PHASE0 = 16'hC000;
  localparam logic [WORD_W-1:0] CMD_PHASE1 = 16'hE000;

  localparam logic [WORD_W-1:0] CONTROL_RST = 16'h2000;
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 25'd0;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 25'd21474836;
  localparam logic [TW_W-1:0] MCLK_RST = 32'd25000000;

  // Request from the sequencer to the divider
  typedef struct packed {
    logic start;
    logic [TW_W-1:0] dividend;
  } div_req_t;

endpackage

// ===== sv/ddsfw_div.sv =====
// ----------------------------------------------------------------------------
// DDS tuning divider
// Restoring divider: (dividend << 28) / divisor, one quotient bit per cycle,
// low 32 quotient bits kept. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module ddsfw_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ddsfw_pkg::div_req_t     req,
  input  logic [31:0]             divisor,
  output logic                    done,
  output logic [31:0]             quotient
);
  import ddsfw_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TW_W-1:0]      num_r;
  logic [TW_W-1:0]      rem_r;
  logic [TW_W-1:0]      q_r;

  logic [TW_W:0] shifted;
  logic [TW_W:0] diff;
  logic          ge;

  assign shifted = {rem_r, num_r[TW_W-1]};
  assign ge = shifted >= {1'b0, divisor};
  assign diff = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: shift numerator bits in, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      rem_r <= '0;
      q_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[TW_W-2:0], 1'b0};
      rem_r <= ge ? diff[TW_W-1:0] : shifted[TW_W-1:0];
      q_r <= {q_r[TW_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule

// ===== sv/ddsfw_seq.sv =====
// ----------------------------------------------------------------------------
// DDS command sequencer
// Clamps and scales frequencies, drives the divider and emits command words
// through an output register.
// ----------------------------------------------------------------------------
module ddsfw_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic [31:0]             in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_spi_word,
  output logic                    out_last,
  output logic [24:0]             out_applied_frequency,
  output logic [31:0]             out_tuning_word,
  input  logic [15:0]             control_word,
  input  logic [24:0]             min_frequency,
  input  logic [24:0]             max_frequency,
  output ddsfw_pkg::div_req_t     div_req,
  input  logic                    div_done,
  input  logic [31:0]             div_quotient
);
  import ddsfw_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [1:0]        idx_r;
  logic              init_r;
  logic [FREQ_W-1:0] freq_r;
  logic [TW_W-1:0]   tune_r;
  logic [TW_W-1:0]   tw_r;
  logic [TW_W-1:0]   scaled_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_last_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic [TW_W-1:0]   out_tw_r;

  logic              accept;
  logic              load_out;
  logic              word_last;
  logic [WORD_W-1:0] word;
  logic [TW_W-1:0]   clamp_lo;
  logic [TW_W-1:0]   clamp;
  logic [FREQ_W+7:0] product;

  assign accept = in_valid && in_ready;
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign word_last = init_r ? (idx_r == 2'd3) : (idx_r == 2'd2);

  // Minimum clamp first, then maximum, so the maximum wins
  assign clamp_lo = (in_value < {7'd0, min_frequency}) ? {7'd0, min_frequency} : in_value;
  assign clamp = (clamp_lo > {7'd0, max_frequency}) ? {7'd0, max_frequency} : clamp_lo;

  // x200 = x128 + x64 + x8
  assign product = {1'b0, freq_r, 7'd0} + {2'b0, freq_r, 6'd0} + {5'd0, freq_r, 3'd0};

  always_comb begin
    if (init_r) begin
      case (idx_r)
        2'd0:    word = CMD_RESET;
        2'd1:    word = CMD_PHASE0;
        2'd2:    word = CMD_PHASE1;
        default: word = control_word;
      endcase
    end else begin
      case (idx_r)
        2'd1:    word = WORD_TAG | {2'b00, tw_r[HALF_W-1:0]};
        2'd2:    word = WORD_TAG | {2'b00, tw_r[2*HALF_W-1:HALF_W]};
        default: word = control_word;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_FREQ: state_nxt = ST_SCALE;
            KIND_INIT: state_nxt = ST_EMIT;
            KIND_TUNE: state_nxt = ST_EMIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCALE:     state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out && word_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    div_req.start = (state_r == ST_DIV_START);
    div_req.dividend = scaled_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      init_r <= 1'b0;
      freq_r <= '0;
      tune_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        idx_r <= '0;
        init_r <= (kind_t'(in_kind) == KIND_INIT);
        if (kind_t'(in_kind) == KIND_FREQ) begin
          freq_r <= clamp[FREQ_W-1:0];
        end
      end else if (load_out) begin
        idx_r <= idx_r + 1'b1;
      end
      if ((state_r == ST_DIV) && div_done) begin
        tune_r <= div_quotient;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind_t'(in_kind) == KIND_TUNE)) begin
      tw_r <= in_value;
    end else if ((state_r == ST_DIV) && div_done) begin
      tw_r <= div_quotient;
    end
    if (state_r == ST_SCALE) begin
      scaled_r <= product[TW_W-1:0];
    end
    if (load_out) begin
      out_word_r <= word;
      out_last_r <= word_last;
      out_freq_r <= freq_r;
      out_tw_r <= tune_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_spi_word = out_word_r;
  assign out_last = out_last_r;
  assign out_applied_frequency = out_freq_r;
  assign out_tuning_word = out_tw_r;

endmodule

// ===== sv/dds_frequency_word_programmer.sv =====
// ----------------------------------------------------------------------------
// DDS frequency word programmer
// Turns commands into 16-bit synthesizer command words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, in_kind, in_value) takes one command item;
// kind 3 is taken and dropped. Output channel (out_valid/out_ready) carries
// each of the command's words in turn, out_last on the command's final word, with the
// stored frequency and tuning word alongside.
// Set-frequency clamps in_value, scales it by 200 and divides (scaled << 28)
// by master_clock in one shared subtract/compare unit, one bit per cycle.
// Its first word is loaded after clamp, scale, divider start, 60 divider
// steps and quotient capture; other commands go from acceptance straight to
// word load. Further words are loaded one after another, and in_ready stays
// low until the final word is loaded. A stalled receiver holds the output
// register and the sequencer waits with in_ready low.
// Reset (synchronous, active low) clears the sequencer and stored state and
// loads the default configuration. Configuration writes take effect at once;
// the user must see that they are issued only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module dds_frequency_word_programmer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_spi_word,
  output logic        out_last,
  output logic [24:0] out_applied_frequency,
  output logic [31:0] out_tuning_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ddsfw_pkg::*;

  logic [WORD_W-1:0] control_r;
  logic [FREQ_W-1:0] min_freq_r;
  logic [FREQ_W-1:0] max_freq_r;
  logic [TW_W-1:0]   mclk_r;

  div_req_t        div_req;
  logic            div_done;
  logic [TW_W-1:0] div_quotient;

  // Configuration registers: write-only, narrowed to their widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= CONTROL_RST;
      min_freq_r <= MIN_FREQ_RST;
      max_freq_r <= MAX_FREQ_RST;
      mclk_r <= MCLK_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CONTROL:  control_r <= cfg_data[WORD_W-1:0];
        REG_MIN_FREQ: min_freq_r <= cfg_data[FREQ_W-1:0];
        REG_MAX_FREQ: max_freq_r <= cfg_data[FREQ_W-1:0];
        REG_MCLK:     mclk_r <= cfg_data;
        default:      control_r <= control_r;
      endcase
    end
  end

  // Command sequencer and output register
  ddsfw_seq u_seq (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_value              (in_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_spi_word          (out_spi_word),
    .out_last              (out_last),
    .out_applied_frequency (out_applied_frequency),
    .out_tuning_word       (out_tuning_word),
    .control_word          (control_r),
    .min_frequency         (min_freq_r),
    .max_frequency         (max_freq_r),
    .div_req               (div_req),
    .div_done              (div_done),
    .div_quotient          (div_quotient)
  );

  // Shared bit-serial divider for the tuning word
  ddsfw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .divisor  (mclk_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule
